FILE: hw/rtl/cassette_tone_framer_core_defines.svh
// Assertion macros for the cassette tone framer RTL.
// Assertion macros only; every asserting module samples on clock and is disabled by reset.
`ifndef CASSETTE_TONE_FRAMER_CORE_DEFINES_SVH
`define CASSETTE_TONE_FRAMER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that a condition holds at every clock edge out of reset.
`define CTF_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define CTF_ASSERT_NEXT(lbl, cond, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`else

`define CTF_ASSERT_ALWAYS(lbl, expr, msg)
`define CTF_ASSERT_NEXT(lbl, cond, expr, msg)

`endif

`endif

FILE: hw/rtl/ctf_pkg.sv
// Shared types and constants for the cassette tone framer.
// No dependencies; used by the interfaces and every module of the block.
package ctf_pkg;

   localparam int FREQ_W      = 15;
   localparam int PER_W       = 9;
   localparam int BYTE_W      = 8;
   localparam int ACT_W       = 2;
   localparam int SYM_W       = 2;
   localparam int NUM_SYMBOLS = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int STEP_W      = 3;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Input action codes
   localparam logic [ACT_W-1:0] ACT_START = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DATA  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_END   = 2'd2;

   // Fixed tones
   localparam logic [FREQ_W-1:0] PILOT_FREQ    = 15'd5000;
   localparam logic [PER_W-1:0]  PILOT_PERIODS = 9'd500;
   localparam logic [FREQ_W-1:0] SYNC_FREQ     = 15'd10000;
   localparam logic [PER_W-1:0]  SYNC_PERIODS  = 9'd2;
   localparam logic [FREQ_W-1:0] END_FREQ      = 15'd3500;
   localparam logic [PER_W-1:0]  END_PERIODS   = 9'd2;
   localparam logic [PER_W-1:0]  SYMBOL_PERIODS = 9'd1;

   // Sequencer steps of the final tone per command
   localparam logic [STEP_W-1:0] STEP_SYNC     = 3'd1;
   localparam logic [STEP_W-1:0] STEP_LAST_SYM = 3'd3;
   localparam logic [STEP_W-1:0] STEP_END_TONE = 3'd4;

   // Symbol frequency register reset values
   localparam logic [FREQ_W-1:0] FREQ_SYM0_RST = 15'd11025;
   localparam logic [FREQ_W-1:0] FREQ_SYM1_RST = 15'd7350;
   localparam logic [FREQ_W-1:0] FREQ_SYM2_RST = 15'd5512;
   localparam logic [FREQ_W-1:0] FREQ_SYM3_RST = 15'd4410;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_DATA,
      CMD_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [BYTE_W-1:0] payload;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [PER_W-1:0]  periods;
      logic              last;
   } tone_type;

endpackage

FILE: hw/rtl/ctf_req_if.sv
// Input channel of the cassette tone framer: frame actions and data bytes.
// Depends on ctf_pkg for field widths.
interface ctf_req_if;
   logic                             valid;
   logic                             ready;
   logic [ctf_pkg::ACT_W-1:0]        action;
   logic [ctf_pkg::BYTE_W-1:0]       data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink   (input valid, input action, input data_byte, output ready);
endinterface

FILE: hw/rtl/ctf_rsp_if.sv
// Result channel of the cassette tone framer: tone commands.
// Depends on ctf_pkg for field widths.
interface ctf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ctf_pkg::FREQ_W-1:0]  tone_freq;
   logic [ctf_pkg::PER_W-1:0]   tone_periods;
   logic                        last_of_run;

   modport source (output valid, output tone_freq, output tone_periods, output last_of_run,
                   input ready);
   modport sink   (input valid, input tone_freq, input tone_periods, input last_of_run,
                   output ready);
endinterface

FILE: hw/rtl/ctf_front.sv
// Front end: accepts input items, classifies them and keeps the running checksum.
// Depends on ctf_pkg and ctf_req_if; pushes commands into ctf_queue.
module ctf_front (
   input  logic                  clock,
   input  logic                  reset,
   ctf_req_if.sink               req_chan,
   input  ctf_pkg::q_status_type q_status,
   output logic                  push,
   output ctf_pkg::cmd_type      push_cmd
);

   logic [ctf_pkg::BYTE_W-1:0] checksum_ff;
   logic [ctf_pkg::BYTE_W-1:0] checksum_in;
   logic                       accept;

   // Take an item whenever the queue has room
   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;

   // Classify the item and update the checksum
   always_comb begin
      push             = 1'b0;
      push_cmd.kind    = ctf_pkg::CMD_DATA;
      push_cmd.payload = req_chan.data_byte;
      checksum_in      = checksum_ff;
      case (req_chan.action)
         ctf_pkg::ACT_START: begin
            push          = accept;
            push_cmd.kind = ctf_pkg::CMD_START;
            if (accept) begin
               checksum_in = '0;
            end
         end
         ctf_pkg::ACT_DATA: begin
            push = accept;
            if (accept) begin
               checksum_in = checksum_ff ^ req_chan.data_byte;
            end
         end
         ctf_pkg::ACT_END: begin
            push             = accept;
            push_cmd.kind    = ctf_pkg::CMD_END;
            push_cmd.payload = checksum_ff;
         end
         default: begin
            // Drop unused action codes
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         checksum_ff <= '0;
      end else begin
         checksum_ff <= checksum_in;
      end
   end

endmodule

FILE: hw/rtl/ctf_queue.sv
// Short command queue between the front end and the tone sequencer.
// Depends on ctf_pkg for the command type and depth.
module ctf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ctf_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output ctf_pkg::cmd_type      pop_cmd,
   output ctf_pkg::q_status_type q_status
);

   localparam logic [ctf_pkg::QPTR_W-1:0] LAST_PTR = ctf_pkg::QPTR_W'(ctf_pkg::QUEUE_DEPTH - 1);
   localparam logic [ctf_pkg::QCNT_W-1:0] FULL_CNT = ctf_pkg::QCNT_W'(ctf_pkg::QUEUE_DEPTH);

   ctf_pkg::cmd_type             mem_ff [ctf_pkg::QUEUE_DEPTH];
   logic [ctf_pkg::QPTR_W-1:0]   wr_ptr_ff;
   logic [ctf_pkg::QPTR_W-1:0]   wr_ptr_in;
   logic [ctf_pkg::QPTR_W-1:0]   rd_ptr_ff;
   logic [ctf_pkg::QPTR_W-1:0]   rd_ptr_in;
   logic [ctf_pkg::QCNT_W-1:0]   count_ff;
   logic [ctf_pkg::QCNT_W-1:0]   count_in;

   assign pop_cmd        = mem_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == FULL_CNT);

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hw/rtl/ctf_back.sv
// Back end: expands queued commands into tone items, one tone per cycle while rsp_chan.ready is high.
// Depends on ctf_pkg, ctf_rsp_if and the assertion macro header.
`include "cassette_tone_framer_core_defines.svh"

module ctf_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [ctf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ctf_pkg::FREQ_W-1:0]       csr_wdata,
   input  ctf_pkg::q_status_type            q_status,
   input  ctf_pkg::cmd_type                 pop_cmd,
   output logic                             pop,
   ctf_rsp_if.source                        rsp_chan
);

   logic [ctf_pkg::FREQ_W-1:0]  freq_ff [ctf_pkg::NUM_SYMBOLS];
   logic                        busy_ff;
   logic                        busy_in;
   logic [ctf_pkg::STEP_W-1:0]  step_ff;
   logic [ctf_pkg::STEP_W-1:0]  step_in;
   ctf_pkg::cmd_kind_type       kind_ff;
   logic [ctf_pkg::BYTE_W-1:0]  byte_ff;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   ctf_pkg::tone_type           out_tone_ff;
   ctf_pkg::tone_type           tone;
   logic [ctf_pkg::FREQ_W-1:0]  sym_freq;
   logic                        advance;

   // Emit a tone when the output register is free or being taken
   assign advance  = busy_ff && (!out_valid_ff || rsp_chan.ready);
   assign sym_freq = freq_ff[byte_ff[ctf_pkg::BYTE_W-1 -: ctf_pkg::SYM_W]];
   assign pop      = !q_status.empty && (!busy_ff || (advance && tone.last));

   // Select the tone for the current step
   always_comb begin
      tone.freq    = sym_freq;
      tone.periods = ctf_pkg::SYMBOL_PERIODS;
      tone.last    = 1'b0;
      case (kind_ff)
         ctf_pkg::CMD_START: begin
            if (step_ff == '0) begin
               tone.freq    = ctf_pkg::PILOT_FREQ;
               tone.periods = ctf_pkg::PILOT_PERIODS;
            end else begin
               tone.freq    = ctf_pkg::SYNC_FREQ;
               tone.periods = ctf_pkg::SYNC_PERIODS;
               tone.last    = 1'b1;
            end
         end
         ctf_pkg::CMD_DATA: begin
            tone.last = (step_ff == ctf_pkg::STEP_LAST_SYM);
         end
         ctf_pkg::CMD_END: begin
            if (step_ff == ctf_pkg::STEP_END_TONE) begin
               tone.freq    = ctf_pkg::END_FREQ;
               tone.periods = ctf_pkg::END_PERIODS;
               tone.last    = 1'b1;
            end
         end
         default: begin
            tone.last = 1'b1;
         end
      endcase
   end

   // Sequence control and output handshake
   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         step_in = step_ff + 1'b1;
         if (tone.last) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         busy_in = 1'b1;
         step_in = '0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold the command payload and the outgoing tone
   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff <= pop_cmd.kind;
         byte_ff <= pop_cmd.payload;
      end else if (advance) begin
         byte_ff <= byte_ff << ctf_pkg::SYM_W;
      end
      if (advance) begin
         out_tone_ff <= tone;
      end
   end

   // Write symbol frequency registers
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff[0] <= ctf_pkg::FREQ_SYM0_RST;
         freq_ff[1] <= ctf_pkg::FREQ_SYM1_RST;
         freq_ff[2] <= ctf_pkg::FREQ_SYM2_RST;
         freq_ff[3] <= ctf_pkg::FREQ_SYM3_RST;
      end else if (csr_wr_en) begin
         freq_ff[csr_index] <= csr_wdata;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.tone_freq    = out_tone_ff.freq;
   assign rsp_chan.tone_periods = out_tone_ff.periods;
   assign rsp_chan.last_of_run  = out_tone_ff.last;

   `CTF_ASSERT_ALWAYS(a_pop_needs_cmd, !pop || !q_status.empty, "pop from empty queue")
   `CTF_ASSERT_ALWAYS(a_start_steps, !(busy_ff && kind_ff == ctf_pkg::CMD_START) || step_ff <= ctf_pkg::STEP_SYNC, "start command ran past sync tone")
   `CTF_ASSERT_NEXT(a_last_ends_cmd, advance && tone.last && !pop, !busy_ff, "sequencer stayed busy after last tone")
   `CTF_ASSERT_NEXT(a_advance_fills, advance, out_valid_ff, "emitted tone not presented")

endmodule

FILE: hw/rtl/cassette_tone_framer_core.sv
// Top level of the cassette tone framer: front end, command queue, tone sequencer.
// Depends on ctf_pkg, ctf_req_if, ctf_rsp_if, ctf_front, ctf_queue and ctf_back.
//
//   channel    dir   handshake          payload
//   req_chan   in    valid/ready        action, data_byte
//   rsp_chan   out   valid/ready        tone_freq, tone_periods, last_of_run
//   csr_*      in    csr_wr_en strobe   csr_index, csr_wdata
//
// The tone sequencer emits one tone per cycle while rsp_chan.ready is high: a start item
// gives 2 tones, a data item 4 and an end item 5, back to back across items; the front end
// accepts one item per cycle while the two-entry command queue has room.
// The first tone of an item passes the queue entry, the sequencer state and the output register.
// Reset is synchronous; it clears the checksum, the queue and the sequencer and
// loads the symbol frequency defaults.
// rsp_chan.ready low holds the output register; the queue absorbs up to two items.
module cassette_tone_framer_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [ctf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ctf_pkg::FREQ_W-1:0]       csr_wdata,
   ctf_req_if.sink                          req_chan,
   ctf_rsp_if.source                        rsp_chan
);

   ctf_pkg::q_status_type q_status;
   ctf_pkg::cmd_type      push_cmd;
   ctf_pkg::cmd_type      pop_cmd;
   logic                  push;
   logic                  pop;

   // Classify items and keep the checksum
   ctf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   // Decouple front and back
   ctf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_status (q_status)
   );

   // Expand commands into tones
   ctf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .pop_cmd   (pop_cmd),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
